[rtl/rsit_pkg.sv]
// ----------------------------------------------------------------------------
// rsit_pkg
// Shared types and codes for the summed-area table unit: port words, the
// command word between front and back, request/status/register codes.
// ----------------------------------------------------------------------------
package rsit_pkg;

  localparam int IDX_W    = 7;   // row/column index and size register width
  localparam int ELEM_W   = 32;  // element field width
  localparam int ELEM_MAX = 48;  // widest supported element
  localparam int SUM_W    = 44;  // table entry / sum width
  localparam int ADDR_W   = 20;  // widest table address (1024 x 1024)

  // request types
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_QUERY   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // result status
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_RECT   = 2'd1;
  localparam logic [1:0] ST_NOT_LOADED = 2'd2;
  localparam logic [1:0] ST_PAST_END   = 2'd3;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // command kinds, front to back
  localparam logic [1:0] CMD_RESULT = 2'd0;  // status only, sum zero
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [ELEM_W-1:0] element_value;
    logic [IDX_W-1:0]        row_first;
    logic [IDX_W-1:0]        col_first;
    logic [IDX_W-1:0]        row_last;
    logic [IDX_W-1:0]        col_last;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] rect_sum;
    logic [1:0]              status;
  } out_word_t;

  // load: addr_a = entry written, addr_b = entry above
  // query: a=(rl,cl) b=(rf-1,cl) c=(rl,cf-1) d=(rf-1,cf-1)
  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [SUM_W-1:0]  elem;
    logic              row_start;
    logic              has_above;
    logic              b_ok;
    logic              c_ok;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_c;
    logic [ADDR_W-1:0] addr_d;
  } cmd_t;

  function automatic logic [IDX_W-1:0] clamp_size(input logic [IDX_W-1:0] v,
                                                  input int limit);
    logic [IDX_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = IDX_W'(1);
    end else if (int'(v) > limit) begin
      res = IDX_W'(limit);
    end
    return res;
  endfunction

endpackage

[rtl/rectangle_sum_integral_table_unit.sv]
// ----------------------------------------------------------------------------
// rectangle_sum_integral_table_unit
// Summed-area table builder and rectangle-sum query engine.
// ----------------------------------------------------------------------------
// Flow: status-only words (error, restart) go out at 1 word/cycle while the
//   back end is idle and the result queue has room. A load or query holds the
//   back end until it is done, as the integral table is single-port (one
//   read and one write per load, four reads per query).
// Reset (rst_n low, synchronous): queues empty, sizes back to 64 (clamped),
//   load position at row 1 / column 1, table marked not loaded.
// ----------------------------------------------------------------------------
module rectangle_sum_integral_table_unit #(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 64,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration: index 0 = rows_in_use, 1 = cols_in_use
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rsit_pkg::IDX_W-1:0]  cfg_data,
  // input queue side
  input  logic                        in_push,
  input  rsit_pkg::in_word_t          in_word,
  output logic                        full,
  // result queue side
  input  logic                        pop,
  output rsit_pkg::out_word_t         out_word,
  output logic                        empty
);

  localparam int CMD_W = $bits(rsit_pkg::cmd_t);
  localparam int RES_W = $bits(rsit_pkg::out_word_t);

  // Front: takes a word when the command queue has room. Load bookkeeping,
  // size registers and all error classification happen here, at accept time,
  // so a word's status is fixed by the order of acceptance.
  logic            cmd_push;
  rsit_pkg::cmd_t  cmd_in;

  // Command queue between front and back.
  logic            cmd_full, cmd_empty, cmd_pop;
  logic [CMD_W-1:0] cmd_head;

  // Result queue: the back end drops one word per command here.
  logic            res_push, res_full;
  rsit_pkg::out_word_t res_in;
  logic [RES_W-1:0] res_head;

  assign full = cmd_full;

  rsit_front #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (cmd_full),
    .in_word   (in_word),
    .cmd_push  (cmd_push),
    .cmd_word  (cmd_in)
  );

  rsit_queue #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_head),
    .empty     (cmd_empty)
  );

  // Back: walks the table memory. Running row sum lives here; a restart
  // reaches it through the row-start flag of the next load.
  rsit_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_word  (rsit_pkg::cmd_t'(cmd_head)),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_word  (res_in)
  );

  rsit_queue #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_head),
    .empty     (empty)
  );

  assign out_word = rsit_pkg::out_word_t'(res_head);

endmodule

[rtl/rsit_queue.sv]
// ----------------------------------------------------------------------------
// rsit_queue
// Small synchronous FIFO; head word is shown while not empty.
// ----------------------------------------------------------------------------
module rsit_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/rsit_front.sv]
// ----------------------------------------------------------------------------
// rsit_front
// Accepts words, holds size registers and load position, classifies each
// word and builds the command for the back end (addresses, flags, status).
// ----------------------------------------------------------------------------
module rsit_front #(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 64,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [rsit_pkg::IDX_W-1:0]         cfg_data,
  input  logic                               in_push,
  input  logic                               in_full,
  input  rsit_pkg::in_word_t                 in_word,
  output logic                               cmd_push,
  output rsit_pkg::cmd_t                     cmd_word
);

  localparam int IW = rsit_pkg::IDX_W;
  localparam int AW = rsit_pkg::ADDR_W;
  localparam int EM = rsit_pkg::ELEM_MAX;
  localparam int SHIFT = EM - ELEMENT_BITS;
  localparam logic [IW-1:0] ROWS_RST = rsit_pkg::clamp_size(IW'(64), MAX_ROWS);
  localparam logic [IW-1:0] COLS_RST = rsit_pkg::clamp_size(IW'(64), MAX_COLS);
  localparam logic [AW-1:0] COLS_A   = AW'(MAX_COLS);

  logic [IW-1:0] rows_r, rows_nxt;
  logic [IW-1:0] cols_r, cols_nxt;
  logic [IW-1:0] load_row_r, load_row_nxt;
  logic [IW-1:0] load_col_r, load_col_nxt;
  logic          ready_r, ready_nxt;

  logic                  accept;
  logic                  bad_rect;
  logic [EM-1:0]         elem_wide;
  logic signed [EM-1:0]  elem_ext;
  logic [AW-1:0]         load_addr;
  logic [AW-1:0]         rl_base, rf_base;
  logic [AW-1:0]         cl_off, cf_off;

  assign accept   = in_push && !in_full;
  assign cmd_push = accept;

  // sign-extend the low ELEMENT_BITS bits
  assign elem_wide = {{(EM - rsit_pkg::ELEM_W){in_word.element_value[rsit_pkg::ELEM_W-1]}},
                      in_word.element_value};
  assign elem_ext  = $signed(elem_wide << SHIFT) >>> SHIFT;

  assign load_addr = AW'(load_row_r - IW'(1)) * COLS_A + AW'(load_col_r - IW'(1));
  assign rl_base   = AW'(in_word.row_last - IW'(1)) * COLS_A;
  assign rf_base   = AW'(in_word.row_first - IW'(2)) * COLS_A;
  assign cl_off    = AW'(in_word.col_last - IW'(1));
  assign cf_off    = AW'(in_word.col_first - IW'(2));

  assign bad_rect = (in_word.row_first == '0) || (in_word.col_first == '0) ||
                    (in_word.row_first > in_word.row_last) ||
                    (in_word.col_first > in_word.col_last) ||
                    (in_word.row_last > rows_r) || (in_word.col_last > cols_r);

  always_comb begin
    rows_nxt     = rows_r;
    cols_nxt     = cols_r;
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    ready_nxt    = ready_r;

    cmd_word           = '0;
    cmd_word.kind      = rsit_pkg::CMD_RESULT;
    cmd_word.status    = rsit_pkg::ST_OK;
    cmd_word.elem      = elem_ext[rsit_pkg::SUM_W-1:0];
    cmd_word.row_start = (load_col_r == IW'(1));
    cmd_word.has_above = (load_row_r > IW'(1));
    cmd_word.b_ok      = (in_word.row_first > IW'(1));
    cmd_word.c_ok      = (in_word.col_first > IW'(1));

    if (cfg_we) begin
      if (cfg_index == rsit_pkg::CFG_ROWS) begin
        rows_nxt = rsit_pkg::clamp_size(cfg_data, MAX_ROWS);
      end else begin
        cols_nxt = rsit_pkg::clamp_size(cfg_data, MAX_COLS);
      end
      load_row_nxt = IW'(1);
      load_col_nxt = IW'(1);
      ready_nxt    = 1'b0;
    end else if (accept) begin
      case (in_word.req_type)
        rsit_pkg::REQ_LOAD: begin
          if (ready_r) begin
            cmd_word.status = rsit_pkg::ST_PAST_END;
          end else begin
            cmd_word.kind   = rsit_pkg::CMD_LOAD;
            cmd_word.addr_a = load_addr;
            cmd_word.addr_b = load_addr - COLS_A;
            if (load_col_r >= cols_r) begin
              load_col_nxt = IW'(1);
              if (load_row_r >= rows_r) begin
                ready_nxt = 1'b1;
              end else begin
                load_row_nxt = load_row_r + IW'(1);
              end
            end else begin
              load_col_nxt = load_col_r + IW'(1);
            end
          end
        end
        rsit_pkg::REQ_QUERY: begin
          if (!ready_r) begin
            cmd_word.status = rsit_pkg::ST_NOT_LOADED;
          end else if (bad_rect) begin
            cmd_word.status = rsit_pkg::ST_BAD_RECT;
          end else begin
            cmd_word.kind   = rsit_pkg::CMD_QUERY;
            cmd_word.addr_a = rl_base + cl_off;
            cmd_word.addr_b = rf_base + cl_off;
            cmd_word.addr_c = rl_base + cf_off;
            cmd_word.addr_d = rf_base + cf_off;
          end
        end
        rsit_pkg::REQ_RESTART: begin
          load_row_nxt = IW'(1);
          load_col_nxt = IW'(1);
          ready_nxt    = 1'b0;
        end
        default: begin
          // unused request type: plain ok result
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= ROWS_RST;
      cols_r     <= COLS_RST;
      load_row_r <= IW'(1);
      load_col_r <= IW'(1);
      ready_r    <= 1'b0;
    end else begin
      rows_r     <= rows_nxt;
      cols_r     <= cols_nxt;
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      ready_r    <= ready_nxt;
    end
  end

endmodule

[rtl/rsit_back.sv]
// ----------------------------------------------------------------------------
// rsit_back
// Executes commands against the single-port integral table: one read and
// one write per load, four reads per query, one result word per command.
// ----------------------------------------------------------------------------
module rsit_back #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_empty,
  input  rsit_pkg::cmd_t       cmd_word,
  output logic                 cmd_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output rsit_pkg::out_word_t  res_word
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int MW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = rsit_pkg::SUM_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LD   = 3'd1;
  localparam logic [2:0] S_Q1   = 3'd2;
  localparam logic [2:0] S_Q2   = 3'd3;
  localparam logic [2:0] S_Q3   = 3'd4;
  localparam logic [2:0] S_Q4   = 3'd5;

  logic [2:0]      state_r, state_nxt;
  rsit_pkg::cmd_t  cmd_r, cmd_nxt;
  logic [SW-1:0]   run_sum_r, run_sum_nxt;
  logic [SW-1:0]   acc_r, acc_nxt;

  logic [SW-1:0]   mem [DEPTH];
  logic [SW-1:0]   rdata_r;
  logic [MW-1:0]   mem_addr;
  logic            mem_we;
  logic [SW-1:0]   mem_wdata;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    run_sum_nxt = run_sum_r;
    acc_nxt     = acc_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res_word    = '0;
    mem_we      = 1'b0;
    mem_addr    = cmd_r.addr_a[MW-1:0];
    mem_wdata   = run_sum_r + (cmd_r.has_above ? rdata_r : '0);

    unique case (state_r)
      S_IDLE: begin
        mem_addr = cmd_word.addr_a[MW-1:0];
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_word;
          unique case (cmd_word.kind)
            rsit_pkg::CMD_LOAD: begin
              mem_addr    = cmd_word.addr_b[MW-1:0];  // entry above
              run_sum_nxt = (cmd_word.row_start ? '0 : run_sum_r) + cmd_word.elem;
              state_nxt   = S_LD;
            end
            rsit_pkg::CMD_QUERY: begin
              state_nxt = S_Q1;
            end
            default: begin
              res_push        = 1'b1;
              res_word.status = cmd_word.status;
            end
          endcase
        end
      end
      S_LD: begin
        mem_we          = 1'b1;
        res_push        = 1'b1;
        res_word.status = rsit_pkg::ST_OK;
        state_nxt       = S_IDLE;
      end
      S_Q1: begin
        acc_nxt   = rdata_r;
        mem_addr  = cmd_r.addr_b[MW-1:0];
        state_nxt = S_Q2;
      end
      S_Q2: begin
        acc_nxt   = acc_r - (cmd_r.b_ok ? rdata_r : '0);
        mem_addr  = cmd_r.addr_c[MW-1:0];
        state_nxt = S_Q3;
      end
      S_Q3: begin
        acc_nxt   = acc_r - (cmd_r.c_ok ? rdata_r : '0);
        mem_addr  = cmd_r.addr_d[MW-1:0];
        state_nxt = S_Q4;
      end
      S_Q4: begin
        res_push          = 1'b1;
        res_word.rect_sum = acc_r + ((cmd_r.b_ok && cmd_r.c_ok) ? rdata_r : '0);
        res_word.status   = rsit_pkg::ST_OK;
        state_nxt         = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      run_sum_r <= '0;
    end else begin
      state_r   <= state_nxt;
      run_sum_r <= run_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    acc_r <= acc_nxt;
  end

  // single-port table, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

`ifndef NO_ASSERTIONS
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_write_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_LD) && ($past(cmd_r.kind) == rsit_pkg::CMD_LOAD ||
                                     $past(cmd_word.kind) == rsit_pkg::CMD_LOAD))
    else $error("table write outside a load");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q1) |-> $past(state_r) == S_IDLE && $past(cmd_pop))
    else $error("query sequence entered without a command");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == S_IDLE) && !cmd_empty)
    else $error("command taken while busy");
`endif

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - summed-area table unit
// Loads matrices of random size and content into the unit one element word
// at a time, then fires rectangle queries at it. A predictor in this file
// mirrors the table, the running row sum and the load position. Each
// accepted result word is compared against the oldest predicted word.
// Both handshake sides idle at random, and one phase stalls the result side
// long enough for the unit to fill up and hold off its input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DIM      = 64;       // DUT default MAX_ROWS / MAX_COLS
  localparam int WORDS_TARGET = 1450;     // directed + wide + random words in
  localparam int CYCLE_LIMIT  = 400000;   // watchdog, several times a slow run
  localparam int LONG_HOLD    = 200;      // result side hold-off, in cycles
  localparam int TAIL_CYCLES  = 10;       // idle time after the final drain

  // request type 3 has no meaning: the unit answers it with status ok
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic                          cfg_index;
  logic [rsit_pkg::IDX_W-1:0]    cfg_data;
  logic                          in_push;
  rsit_pkg::in_word_t            in_word;
  logic                          full;
  logic                          pop;
  rsit_pkg::out_word_t           out_word;
  logic                          empty;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rectangle_sum_integral_table_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_word  (in_word),
    .full     (full),
    .pop      (pop),
    .out_word (out_word),
    .empty    (empty)
  );

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the table, the load cursor and sizes
  // --------------------------------------------------------------------------
  logic [rsit_pkg::SUM_W-1:0] sat_mem [TBL_DIM][TBL_DIM];
  logic [rsit_pkg::SUM_W-1:0] row_acc;      // running sum of the row being loaded
  int               ld_row;       // 1-based load position
  int               ld_col;
  int               rows_used;    // clamped register values
  int               cols_used;
  bit               sat_ready;    // full table loaded

  rsit_pkg::out_word_t sum_expect_q [$];

  int               words_sent = 0;
  int               results_seen = 0;
  int               err_count = 0;
  int               cycle_count = 0;
  int               status_seen [4] = '{default: 0};

  bit               no_idle = 1'b0;    // both sides run without gaps
  int               hold_cycles = 0;   // one-shot long hold for the receiver

  function automatic void sat_restart();
    row_acc   = '0;
    ld_row    = 1;
    ld_col    = 1;
    sat_ready = 1'b0;
  endfunction

  function automatic void sat_reset();
    foreach (sat_mem[i, j]) sat_mem[i][j] = '0;
    rows_used = TBL_DIM;
    cols_used = TBL_DIM;
    sat_restart();
  endfunction

  // register write: value 0 acts as 1, above the table size acts as the size;
  // either register also restarts the load
  function automatic void sat_set_size(input logic idx,
                                       input logic [rsit_pkg::IDX_W-1:0] data);
    int v;
    v = int'(data);
    if (v < 1) v = 1;
    else if (v > TBL_DIM) v = TBL_DIM;
    if (idx == rsit_pkg::CFG_ROWS) rows_used = v;
    else cols_used = v;
    sat_restart();
  endfunction

  // row 0 and column 0 of the integral read as zero
  function automatic logic [rsit_pkg::SUM_W-1:0] sat_at(input int r, input int c);
    if (r == 0 || c == 0) return '0;
    return sat_mem[r-1][c-1];
  endfunction

  // one input word in, one predicted result word out
  function automatic rsit_pkg::out_word_t sat_step(input rsit_pkg::in_word_t w);
    rsit_pkg::out_word_t        res;
    logic [rsit_pkg::SUM_W-1:0] elem;
    logic [rsit_pkg::SUM_W-1:0] above;
    int                         rf, cf, rl, cl;
    res.rect_sum = '0;
    res.status   = rsit_pkg::ST_OK;
    case (w.req_type)
      rsit_pkg::REQ_LOAD: begin
        if (sat_ready) begin
          res.status = rsit_pkg::ST_PAST_END;
        end else begin
          elem    = {{(rsit_pkg::SUM_W-rsit_pkg::ELEM_W){
                       w.element_value[rsit_pkg::ELEM_W-1]}}, w.element_value};
          above   = sat_at(ld_row - 1, ld_col);
          row_acc = row_acc + elem;
          sat_mem[ld_row-1][ld_col-1] = above + row_acc;
          if (ld_col >= cols_used) begin
            ld_col  = 1;
            row_acc = '0;
            if (ld_row >= rows_used) sat_ready = 1'b1;
            else ld_row++;
          end else begin
            ld_col++;
          end
        end
      end
      rsit_pkg::REQ_QUERY: begin
        rf = int'(w.row_first);
        cf = int'(w.col_first);
        rl = int'(w.row_last);
        cl = int'(w.col_last);
        // not-loaded wins over a bad rectangle
        if (!sat_ready) begin
          res.status = rsit_pkg::ST_NOT_LOADED;
        end else if (rf < 1 || cf < 1 || rf > rl || cf > cl ||
                     rl > rows_used || cl > cols_used) begin
          res.status = rsit_pkg::ST_BAD_RECT;
        end else begin
          res.rect_sum = sat_at(rl, cl) - sat_at(rf - 1, cl)
                       - sat_at(rl, cf - 1) + sat_at(rf - 1, cf - 1);
        end
      end
      rsit_pkg::REQ_RESTART: sat_restart();
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: samples handshakes at the edge, updates predictor, checks words
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rsit_pkg::out_word_t want;
    if (!rst_n) begin
      sat_reset();
    end else begin
      if (cfg_we) sat_set_size(cfg_index, cfg_data);
      // check before predicting: a word pushed now cannot come out now
      if (pop && !empty) begin
        results_seen++;
        status_seen[out_word.status]++;
        if (sum_expect_q.size() == 0) begin
          err_count++;
          $error("result word with none expected: rect_sum %0d status %0d",
                 out_word.rect_sum, out_word.status);
        end else begin
          want = sum_expect_q.pop_front();
          if (out_word.rect_sum !== want.rect_sum) begin
            err_count++;
            $error("rect_sum: expected %0d, got %0d", want.rect_sum, out_word.rect_sum);
          end
          if (out_word.status !== want.status) begin
            err_count++;
            $error("status: expected %0d, got %0d", want.status, out_word.status);
          end
        end
      end
      if (in_push && !full) sum_expect_q.push_back(sat_step(in_word));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("watchdog: %0d words still expected", sum_expect_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stall per word, plus the one-shot long hold
  // --------------------------------------------------------------------------
  initial begin : result_drain
    int stall;
    pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Word builders: unused fields carry random bits
  // --------------------------------------------------------------------------
  function automatic rsit_pkg::in_word_t noise_word();
    rsit_pkg::in_word_t w;
    w.req_type      = 2'($urandom_range(0, 3));
    w.element_value = $urandom;
    w.row_first     = rsit_pkg::IDX_W'($urandom_range(0, 127));
    w.col_first     = rsit_pkg::IDX_W'($urandom_range(0, 127));
    w.row_last      = rsit_pkg::IDX_W'($urandom_range(0, 127));
    w.col_last      = rsit_pkg::IDX_W'($urandom_range(0, 127));
    return w;
  endfunction

  function automatic rsit_pkg::in_word_t ctrl_word(input logic [1:0] req);
    rsit_pkg::in_word_t w;
    w = noise_word();
    w.req_type = req;
    return w;
  endfunction

  function automatic rsit_pkg::in_word_t load_word(input logic [rsit_pkg::ELEM_W-1:0] v);
    rsit_pkg::in_word_t w;
    w = ctrl_word(rsit_pkg::REQ_LOAD);
    w.element_value = v;
    return w;
  endfunction

  function automatic rsit_pkg::in_word_t query_word(input int rf, input int cf,
                                                    input int rl, input int cl);
    rsit_pkg::in_word_t w;
    w = ctrl_word(rsit_pkg::REQ_QUERY);
    w.row_first = rsit_pkg::IDX_W'(rf);
    w.col_first = rsit_pkg::IDX_W'(cf);
    w.row_last  = rsit_pkg::IDX_W'(rl);
    w.col_last  = rsit_pkg::IDX_W'(cl);
    return w;
  endfunction

  // any rectangle inside the current size
  function automatic rsit_pkg::in_word_t valid_query();
    int rf, cf;
    rf = $urandom_range(1, rows_used);
    cf = $urandom_range(1, cols_used);
    return query_word(rf, cf, $urandom_range(rf, rows_used), $urandom_range(cf, cols_used));
  endfunction

  // extremes often, small values often, full range otherwise
  function automatic logic [rsit_pkg::ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------
  // push stays high into the next call when no gap is drawn
  task automatic send_word(input rsit_pkg::in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
  endtask

  // sender idles until every predicted word has come back
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sum_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [rsit_pkg::IDX_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sizes(input int r, input int c);
    drain();
    write_reg(rsit_pkg::CFG_ROWS, rsit_pkg::IDX_W'(r));
    write_reg(rsit_pkg::CFG_COLS, rsit_pkg::IDX_W'(c));
  endtask

  // raster order, rows_used x cols_used elements
  task automatic load_table();
    for (int r = 0; r < rows_used; r++)
      for (int c = 0; c < cols_used; c++)
        send_word(load_word(pick_elem()));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // reset sizes 64 x 64, nothing loaded
    send_word(query_word(1, 1, 64, 64));
    send_word(ctrl_word(REQ_UNUSED));
    send_word(ctrl_word(rsit_pkg::REQ_RESTART));
    // zero in both registers counts as a 1 x 1 table
    set_sizes(0, 0);
    send_word(load_word(32'h7FFF_FFFF));
    send_word(load_word(32'h8000_0000));        // load past the end
    send_word(query_word(1, 1, 1, 1));
    send_word(query_word(0, 1, 1, 1));          // first index zero
    send_word(query_word(1, 1, 2, 1));          // beyond rows in use
    send_word(query_word(127, 127, 127, 127));
    // 2 x 2 with extreme elements
    set_sizes(2, 2);
    send_word(load_word(32'h8000_0000));
    send_word(load_word(32'h7FFF_FFFF));
    send_word(load_word(32'hFFFF_FFFF));
    send_word(load_word(32'h8000_0000));
    send_word(query_word(1, 1, 2, 2));
    send_word(query_word(2, 2, 2, 2));
    send_word(query_word(1, 2, 1, 2));
    send_word(query_word(2, 1, 2, 1));
    send_word(query_word(2, 1, 1, 1));          // row first above row last
    send_word(query_word(1, 2, 1, 1));          // col first above col last
    send_word(query_word(1, 0, 1, 1));
    send_word(query_word(1, 1, 1, 3));          // beyond cols in use
    send_word(ctrl_word(REQ_UNUSED));
    send_word(ctrl_word(rsit_pkg::REQ_RESTART));
    send_word(query_word(1, 1, 1, 1));          // restart dropped the table
    // above-range values clamp to 64; not-loaded still beats bad rectangle
    set_sizes(127, 65);
    send_word(query_word(1, 1, 65, 65));
  endtask

  // one register at 64 at a time keeps the load short
  task automatic test_wide_tables();
    set_sizes(64, 2);
    load_table();
    send_word(query_word(1, 1, 64, 2));
    send_word(query_word(64, 2, 64, 2));
    send_word(query_word(33, 1, 64, 1));
    send_word(query_word(1, 1, 65, 2));
    repeat (10) send_word(valid_query());
    set_sizes(2, 64);
    load_table();
    send_word(query_word(1, 1, 2, 64));
    send_word(query_word(2, 64, 2, 64));
    send_word(query_word(1, 1, 2, 65));
    repeat (10) send_word(valid_query());
  endtask

  // receiver holds off while the sender keeps pushing: queues fill, full rises
  task automatic test_backpressure();
    set_sizes(4, 4);
    load_table();
    drain();
    hold_cycles = LONG_HOLD;
    no_idle     = 1'b1;
    repeat (60) begin
      if ($urandom_range(0, 1) == 0) send_word(valid_query());
      else send_word(query_word(3, 1, 2, 1));   // status-only, fast path
    end
    drain();
    no_idle = 1'b0;
    repeat (5) send_word(valid_query());
  endtask

  // sessions: resize, maybe a broken load, full load, mixed queries
  task automatic test_random_sessions();
    int pick, rr, cc, nq, k;
    while (words_sent < WORDS_TARGET) begin
      no_idle = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        rr = $urandom_range(1, 127);
        cc = $urandom_range(0, 3);
      end else if (pick == 1) begin
        rr = $urandom_range(0, 3);
        cc = $urandom_range(1, 127);
      end else begin
        rr = $urandom_range(1, 6);
        cc = $urandom_range(1, 6);
      end
      // a single write also restarts; only when the other size stays small
      if ($urandom_range(0, 3) == 0 && rows_used <= 8 && cols_used <= 8) begin
        drain();
        if ($urandom_range(0, 1) == 0) write_reg(rsit_pkg::CFG_ROWS, rsit_pkg::IDX_W'(rr));
        else write_reg(rsit_pkg::CFG_COLS, rsit_pkg::IDX_W'(cc));
      end else begin
        set_sizes(rr, cc);
      end
      // query too early, part of a load, then a restart
      if ($urandom_range(0, 3) == 0) begin
        send_word(valid_query());
        k = $urandom_range(0, rows_used * cols_used - 1);
        repeat (k) send_word(load_word(pick_elem()));
        send_word(ctrl_word(rsit_pkg::REQ_RESTART));
      end
      load_table();
      nq = $urandom_range(6, 24);
      repeat (nq) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) send_word(valid_query());
        else if (pick < 16) send_word(query_word($urandom_range(0, 127),
                                                 $urandom_range(0, 127),
                                                 $urandom_range(0, 127),
                                                 $urandom_range(0, 127)));
        else if (pick == 16) send_word(load_word(pick_elem()));
        else if (pick == 17) send_word(ctrl_word(REQ_UNUSED));
        else if (pick == 18) send_word(query_word(1, 1, rows_used, cols_used));
        else send_word(noise_word());
      end
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= rsit_pkg::CFG_ROWS;
    cfg_data  <= '0;
    in_push   <= 1'b0;
    in_word   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_wide_tables();
    test_backpressure();
    test_random_sessions();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words in, %0d results: %0d ok, %0d bad rect, %0d not loaded, %0d past end",
             words_sent, results_seen, status_seen[rsit_pkg::ST_OK],
             status_seen[rsit_pkg::ST_BAD_RECT], status_seen[rsit_pkg::ST_NOT_LOADED],
             status_seen[rsit_pkg::ST_PAST_END]);
    $display("sizes 1 to 64 per side incl. clamped writes, %0d-cycle result stall, %0d cycles",
             LONG_HOLD, cycle_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
